// ----- sv/safc_pkg.sv -----
package safc_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned PosW     = 3;
    localparam int unsigned FrameLen = 8;
    localparam int unsigned StoreLen = FrameLen - 1;
    localparam int unsigned AngleW   = 14;
    localparam int unsigned RollW    = 6;

    localparam logic [ByteW-1:0] CrcInit  = 8'hFF;
    localparam logic [ByteW-1:0] CrcPoly  = 8'h2F;
    localparam logic [PosW-1:0]  LastPos  = 3'd7;
    localparam logic [PosW-1:0]  FirstPos = 3'd0;

    typedef struct packed {
        logic [AngleW-1:0] alpha_angle;
        logic [AngleW-1:0] beta_angle;
        logic [1:0]        error_bits;
        logic [ByteW-1:0]  virtual_gain;
        logic [RollW-1:0]  rolling_counter;
        logic              crc_ok;
        logic              frame_valid;
    } t_result;

    // one byte through the crc, msb first, no reflection
    function automatic logic [ByteW-1:0] crc8_step(input logic [ByteW-1:0] crc,
                                                   input logic [ByteW-1:0] data);
        logic [ByteW-1:0] r;
        r = crc ^ data;
        for (int k = 0; k < ByteW; k++) begin
            if (r[ByteW-1]) begin
                r = {r[ByteW-2:0], 1'b0} ^ CrcPoly;
            end else begin
                r = {r[ByteW-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

// ----- sv/safc_in_stage.sv -----
module safc_in_stage (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [safc_pkg::ByteW-1:0] i_rx_byte,
    input  logic                       i_frame_start,
    input  logic                       i_advance,
    output logic                       o_valid,
    output logic [safc_pkg::ByteW-1:0] o_byte,
    output logic                       o_start
);
    import safc_pkg::*;

    logic             r_valid;
    logic [ByteW-1:0] r_byte;
    logic             r_start;
    logic             load;

    // the held word moves on in the same cycle a new one is taken
    assign o_ready = !r_valid || i_advance;
    assign load    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte  <= i_rx_byte;
            r_start <= i_frame_start;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_start = r_start;

endmodule

// ----- sv/safc_frame.sv -----
module safc_frame (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_advance,
    input  logic [safc_pkg::ByteW-1:0] i_byte,
    input  logic                       i_start,
    output logic                       o_last,
    output safc_pkg::t_result          o_result
);
    import safc_pkg::*;

    logic [PosW-1:0]  r_pos;
    logic [PosW-1:0]  n_pos;
    logic [ByteW-1:0] r_crc;
    logic [ByteW-1:0] n_crc;
    logic [ByteW-1:0] r_frame [StoreLen];

    logic [PosW-1:0]  pos_eff;
    logic [ByteW-1:0] crc_eff;
    logic             crc_ok;
    logic             valid;

    // a start flag restarts the frame at byte 0 before this word is placed
    assign pos_eff = i_start ? FirstPos : r_pos;
    assign crc_eff = i_start ? CrcInit : r_crc;
    assign o_last  = (pos_eff == LastPos);

    always_comb begin
        if (o_last) begin
            n_pos = FirstPos;
            n_crc = CrcInit;
        end else begin
            n_pos = pos_eff + 1'b1;
            n_crc = crc8_step(crc_eff, i_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= FirstPos;
            r_crc <= CrcInit;
        end else if (i_advance) begin
            r_pos <= n_pos;
            r_crc <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && !o_last) begin
            r_frame[pos_eff] <= i_byte;
        end
    end

    assign crc_ok = ((~crc_eff) == i_byte);
    assign valid  = crc_ok && r_frame[1][7];

    always_comb begin
        o_result.alpha_angle     = valid ? {r_frame[1][5:0], r_frame[0]} : '0;
        o_result.beta_angle      = valid ? {r_frame[3][5:0], r_frame[2]} : '0;
        o_result.error_bits      = r_frame[1][7:6];
        o_result.virtual_gain    = r_frame[4];
        o_result.rolling_counter = r_frame[6][RollW-1:0];
        o_result.crc_ok          = crc_ok;
        o_result.frame_valid     = valid;
    end

    a_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && o_last |=> r_pos == FirstPos && r_crc == CrcInit)
        else $error("frame end did not restart position and crc");

    a_pos_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && !o_last |=> r_pos == $past(pos_eff) + 1'b1)
        else $error("byte position did not step");

endmodule

// ----- sv/sensor_answer_frame_checker.sv -----
// a result is registered in the cycle after byte 7 of a frame leaves the input stage
// one byte per cycle when not stalled; one crc step between input and state registers
// a result waiting in the output register does not stall bytes 0 to 6 of the next frame
// reset (synchronous, active low) empties both word registers, sets byte position 0
// and crc 0xFF; stored frame bytes are not cleared and are always written before use
module sensor_answer_frame_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [safc_pkg::ByteW-1:0]  i_rx_byte,
    input  logic                        i_frame_start,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [safc_pkg::AngleW-1:0] o_alpha_angle,
    output logic [safc_pkg::AngleW-1:0] o_beta_angle,
    output logic [1:0]                  o_error_bits,
    output logic [safc_pkg::ByteW-1:0]  o_virtual_gain,
    output logic [safc_pkg::RollW-1:0]  o_rolling_counter,
    output logic                        o_crc_ok,
    output logic                        o_frame_valid
);
    import safc_pkg::*;

    logic             st_valid;
    logic [ByteW-1:0] st_byte;
    logic             st_start;
    logic             st_last;
    logic             advance;
    logic             out_free;
    t_result          result;
    t_result          r_out;
    logic             r_out_valid;

    assign out_free = !r_out_valid || i_ready;
    // only byte 7 needs room in the output register
    assign advance  = st_valid && (!st_last || out_free);

    safc_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_rx_byte    (i_rx_byte),
        .i_frame_start(i_frame_start),
        .i_advance    (advance),
        .o_valid      (st_valid),
        .o_byte       (st_byte),
        .o_start      (st_start)
    );

    safc_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_advance(advance),
        .i_byte  (st_byte),
        .i_start (st_start),
        .o_last  (st_last),
        .o_result(result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && st_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && st_last) begin
            r_out <= result;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_alpha_angle     = r_out.alpha_angle;
    assign o_beta_angle      = r_out.beta_angle;
    assign o_error_bits      = r_out.error_bits;
    assign o_virtual_gain    = r_out.virtual_gain;
    assign o_rolling_counter = r_out.rolling_counter;
    assign o_crc_ok          = r_out.crc_ok;
    assign o_frame_valid     = r_out.frame_valid;

    a_valid_needs_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_valid |-> o_crc_ok && o_error_bits[1])
        else $error("frame marked valid without crc match and error bit 1");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_frame_valid |-> o_alpha_angle == '0 && o_beta_angle == '0)
        else $error("invalid frame reports nonzero angles");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(r_out))
        else $error("pending result was overwritten");

endmodule
